// ===== rtl/hsv2rgb_pkg.sv =====
// ============================================================================
// hsv2rgb_pkg
// Shared constants for the HSV-plus-alpha to packed RGBA color converter.
// ============================================================================
`default_nettype none

package hsv2rgb_pkg;

   // Default number of fraction bits of the fixed-point inputs.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Hue sector: integer part of hue times six, 0 to 5.
   localparam int SECTOR_W = 3;

   // One color channel byte and the packed result word.
   localparam int CHAN_W = 8;
   localparam int RSP_W  = 4 * CHAN_W;

   // Sector codes, named by the pair of primaries the sector runs between.
   localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW   = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN   = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE    = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA_RED  = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/hsv2rgb_prep.sv =====
// ============================================================================
// hsv2rgb_prep
// First pipeline stage: clamps the unit inputs to 1.0 and splits hue times
// six into a sector and a fraction.
// ============================================================================
`default_nettype none

module hsv2rgb_prep
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire logic [FRAC_BITS-1:0]  in_hue,
   input  wire logic [FRAC_BITS:0]    in_sat,
   input  wire logic [FRAC_BITS:0]    in_val,
   input  wire logic [FRAC_BITS:0]    in_alpha,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic [SECTOR_W-1:0]   out_sector,
   output      logic [FRAC_BITS-1:0]  out_frac,
   output      logic [FRAC_BITS:0]    out_sat,
   output      logic [FRAC_BITS:0]    out_val,
   output      logic [FRAC_BITS:0]    out_alpha
);

   localparam int          H6_W = FRAC_BITS + SECTOR_W;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic                 valid_ff;
   logic [SECTOR_W-1:0]  sector_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [FRAC_BITS:0]   sat_ff, val_ff, alpha_ff;
   logic [FRAC_BITS:0]   sat_in, val_in, alpha_in;
   logic [H6_W-1:0]      hue6_in;

   // Values above 1.0 saturate to 1.0.
   assign sat_in   = (in_sat   > ONE) ? ONE : in_sat;
   assign val_in   = (in_val   > ONE) ? ONE : in_val;
   assign alpha_in = (in_alpha > ONE) ? ONE : in_alpha;

   // Hue times six as four times plus two times.
   assign hue6_in = (H6_W'(in_hue) << 2) + (H6_W'(in_hue) << 1);

   // The stage takes a new request when empty or when its content moves on.
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sector_ff <= hue6_in[H6_W-1:FRAC_BITS];
         frac_ff   <= hue6_in[FRAC_BITS-1:0];
         sat_ff    <= sat_in;
         val_ff    <= val_in;
         alpha_ff  <= alpha_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sector = sector_ff;
   assign out_frac   = frac_ff;
   assign out_sat    = sat_ff;
   assign out_val    = val_ff;
   assign out_alpha  = alpha_ff;

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_terms.sv =====
// ============================================================================
// hsv2rgb_terms
// Two multiplier stages that form p = v(1-s), q = v(1-s*f) and
// t = v(1-s(1-f)) in fixed point, truncating after each product.
// ============================================================================
`default_nettype none

module hsv2rgb_terms
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire logic [SECTOR_W-1:0]   in_sector,
   input  wire logic [FRAC_BITS-1:0]  in_frac,
   input  wire logic [FRAC_BITS:0]    in_sat,
   input  wire logic [FRAC_BITS:0]    in_val,
   input  wire logic [FRAC_BITS:0]    in_alpha,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic [SECTOR_W-1:0]   out_sector,
   output      logic [FRAC_BITS:0]    out_val,
   output      logic [FRAC_BITS:0]    out_alpha,
   output      logic [FRAC_BITS:0]    out_p,
   output      logic [FRAC_BITS:0]    out_q,
   output      logic [FRAC_BITS:0]    out_t
);

   localparam int          PROD_W = 2 * FRAC_BITS + 2;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // First multiplier stage registers.
   logic                 a_valid_ff;
   logic                 a_ready;
   logic [SECTOR_W-1:0]  a_sector_ff;
   logic [FRAC_BITS:0]   a_val_ff, a_alpha_ff, a_p_ff, a_sf_ff, a_sfc_ff;

   // Second multiplier stage registers.
   logic                 b_valid_ff;
   logic [SECTOR_W-1:0]  b_sector_ff;
   logic [FRAC_BITS:0]   b_val_ff, b_alpha_ff, b_p_ff, b_q_ff, b_t_ff;

   logic [FRAC_BITS:0]   frac_comp_in;
   logic [PROD_W-1:0]    sf_prod_in, sfc_prod_in, p_prod_in;
   logic [PROD_W-1:0]    q_prod_in, t_prod_in;

   // Stage A: s*f, s*(1-f) and v*(1-s).
   assign frac_comp_in = ONE - (FRAC_BITS+1)'(in_frac);
   assign sf_prod_in   = PROD_W'(in_sat) * PROD_W'(in_frac);
   assign sfc_prod_in  = PROD_W'(in_sat) * PROD_W'(frac_comp_in);
   assign p_prod_in    = PROD_W'(in_val) * PROD_W'(ONE - in_sat);

   assign a_ready  = !b_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_sector_ff <= in_sector;
         a_val_ff    <= in_val;
         a_alpha_ff  <= in_alpha;
         a_p_ff      <= p_prod_in[2*FRAC_BITS:FRAC_BITS];
         a_sf_ff     <= sf_prod_in[2*FRAC_BITS:FRAC_BITS];
         a_sfc_ff    <= sfc_prod_in[2*FRAC_BITS:FRAC_BITS];
      end
   end

   // Stage B: v*(1-s*f) and v*(1-s*(1-f)).
   assign q_prod_in = PROD_W'(a_val_ff) * PROD_W'(ONE - a_sf_ff);
   assign t_prod_in = PROD_W'(a_val_ff) * PROD_W'(ONE - a_sfc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && a_ready) begin
         b_sector_ff <= a_sector_ff;
         b_val_ff    <= a_val_ff;
         b_alpha_ff  <= a_alpha_ff;
         b_p_ff      <= a_p_ff;
         b_q_ff      <= q_prod_in[2*FRAC_BITS:FRAC_BITS];
         b_t_ff      <= t_prod_in[2*FRAC_BITS:FRAC_BITS];
      end
   end

   assign out_valid  = b_valid_ff;
   assign out_sector = b_sector_ff;
   assign out_val    = b_val_ff;
   assign out_alpha  = b_alpha_ff;
   assign out_p      = b_p_ff;
   assign out_q      = b_q_ff;
   assign out_t      = b_t_ff;

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_pack.sv =====
// ============================================================================
// hsv2rgb_pack
// Last stage: orders the channels by sector, scales each to a byte and
// holds the packed color in the output register.
// ============================================================================
`default_nettype none

module hsv2rgb_pack
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire logic [SECTOR_W-1:0]   in_sector,
   input  wire logic [FRAC_BITS:0]    in_val,
   input  wire logic [FRAC_BITS:0]    in_alpha,
   input  wire logic [FRAC_BITS:0]    in_p,
   input  wire logic [FRAC_BITS:0]    in_q,
   input  wire logic [FRAC_BITS:0]    in_t,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic [RSP_W-1:0]      out_color
);

   logic                 valid_ff;
   logic [RSP_W-1:0]     color_ff;
   logic [FRAC_BITS:0]   red_in, green_in, blue_in;
   logic [RSP_W-1:0]     color_in;

   // Scales a unit value to a byte: floor(x * 255 / 1.0), with x * 255 as
   // x * 256 - x.
   function automatic logic [CHAN_W-1:0] to_byte(input logic [FRAC_BITS:0] x);
      logic [FRAC_BITS+CHAN_W:0] scaled;
      scaled = {x, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, x};
      return scaled[FRAC_BITS+CHAN_W-1:FRAC_BITS];
   endfunction

   // Channel order per sector. Zero saturation needs no branch: p, q and t
   // all equal v then.
   always_comb begin
      case (in_sector)
         SECTOR_RED_YELLOW: begin
            red_in = in_val; green_in = in_t;   blue_in = in_p;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = in_q;   green_in = in_val; blue_in = in_p;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = in_p;   green_in = in_val; blue_in = in_t;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = in_p;   green_in = in_q;   blue_in = in_val;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = in_t;   green_in = in_p;   blue_in = in_val;
         end
         default: begin
            red_in = in_val; green_in = in_p;   blue_in = in_q;
         end
      endcase
   end

   assign color_in = {to_byte(in_alpha), to_byte(blue_in),
                      to_byte(green_in), to_byte(red_in)};

   // Output register; it loads whenever it is empty or being read out.
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         color_ff <= color_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_color = color_ff;

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_color.sv =====
// ============================================================================
// hsv_to_rgb_color
// HSV-plus-alpha to packed 32-bit RGBA color converter, streaming top level.
// ============================================================================
// Each request carries a hue (a fraction of a turn) and saturation,
// brightness and opacity in unsigned fixed point with FRAC_BITS fraction
// bits, where 2^FRAC_BITS means 1.0 and larger values are taken as 1.0.
// The response is one 32-bit word with red in bits 7:0, green 15:8, blue
// 23:16 and alpha 31:24, each channel floor(x * 255). The block takes one
// request per clock while the response side is ready. A request passes
// through a clamp and sector stage, two multiplier stages for the p, q
// and t terms, and the output register. Each stage moves on by itself, so
// bubbles are filled and a request is taken while a response still waits.
// The block holds no state between requests.
// ============================================================================
`default_nettype none

module hsv_to_rgb_color
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   localparam int REQ_FIELDS_W = 4 * FRAC_BITS + 3,
   localparam int REQ_W = ((REQ_FIELDS_W + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   // Fields from bit 0 up: hue, saturation, brightness, opacity, zero fill.
   input  wire logic [REQ_W-1:0]  req_tdata,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   // Fields from bit 0 up: color.
   output      logic [RSP_W-1:0]  rsp_tdata
);

   logic [FRAC_BITS-1:0] hue;
   logic [FRAC_BITS:0]   saturation, brightness, opacity;

   logic                 prep_valid, prep_ready;
   logic [SECTOR_W-1:0]  prep_sector;
   logic [FRAC_BITS-1:0] prep_frac;
   logic [FRAC_BITS:0]   prep_sat, prep_val, prep_alpha;

   logic                 terms_valid, terms_ready;
   logic [SECTOR_W-1:0]  terms_sector;
   logic [FRAC_BITS:0]   terms_val, terms_alpha, terms_p, terms_q, terms_t;

   // Request field unpacking.
   assign hue        = req_tdata[FRAC_BITS-1:0];
   assign saturation = req_tdata[2*FRAC_BITS:FRAC_BITS];
   assign brightness = req_tdata[3*FRAC_BITS+1:2*FRAC_BITS+1];
   assign opacity    = req_tdata[4*FRAC_BITS+2:3*FRAC_BITS+2];

   hsv2rgb_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_hue     (hue),
      .in_sat     (saturation),
      .in_val     (brightness),
      .in_alpha   (opacity),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .out_sector (prep_sector),
      .out_frac   (prep_frac),
      .out_sat    (prep_sat),
      .out_val    (prep_val),
      .out_alpha  (prep_alpha)
   );

   hsv2rgb_terms #(
      .FRAC_BITS (FRAC_BITS)
   ) u_terms (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prep_valid),
      .in_ready   (prep_ready),
      .in_sector  (prep_sector),
      .in_frac    (prep_frac),
      .in_sat     (prep_sat),
      .in_val     (prep_val),
      .in_alpha   (prep_alpha),
      .out_valid  (terms_valid),
      .out_ready  (terms_ready),
      .out_sector (terms_sector),
      .out_val    (terms_val),
      .out_alpha  (terms_alpha),
      .out_p      (terms_p),
      .out_q      (terms_q),
      .out_t      (terms_t)
   );

   hsv2rgb_pack #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pack (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (terms_valid),
      .in_ready   (terms_ready),
      .in_sector  (terms_sector),
      .in_val     (terms_val),
      .in_alpha   (terms_alpha),
      .in_p       (terms_p),
      .in_q       (terms_q),
      .in_t       (terms_t),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_color  (rsp_tdata)
   );

   // An open response side leaves no stage blocked.
   a_ready_chain : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request side stalled while response side is ready");

   // Reset empties the output register.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // With the response side held open, an accepted request comes out as a response.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("request lost in the pipeline");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ============================================================================
// tb
// Stream-level testbench for the HSV-plus-alpha to RGBA color converter.
// ============================================================================
// A queue of pending requests is filled up front with directed corner colors
// (sector edges, grey, full and over-range fractions) and then with random
// colors. A clocked driver presents them on the request channel with random
// gaps. A clocked monitor takes responses with random stalls and compares
// each one with the color that a local fixed-point predictor worked out for
// the matching request. The run ends once every predicted color has come back.
// ============================================================================
`default_nettype none

module tb
   import hsv2rgb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB          = FRAC_BITS_DEFAULT;
   localparam int REQ_W       = ((4 * FB + 3 + 7) / 8) * 8;
   localparam int ONE         = 1 << FB;
   localparam int UNIT_MAX    = (1 << (FB + 1)) - 1;
   localparam int RANDOM_REQS = 1000;
   localparam int CALM_TAIL   = 100;
   localparam int CYCLE_LIMIT = 200000;
   localparam int FLUSH_WAIT  = 12;

   typedef logic [REQ_W-1:0] req_word_type;

   // One color request plus how the driver should pace it.
   typedef struct {
      logic [FB-1:0] hue;
      logic [FB:0]   saturation;
      logic [FB:0]   brightness;
      logic [FB:0]   opacity;
      int            gap_before;
      bit            drain_first;
   } hsv_request_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   hsv_request_type   pending_requests[$];
   logic [RSP_W-1:0]  expected_colors[$];
   hsv_request_type   current_request;
   bit                request_loaded = 1'b0;
   int                gap_left = 0;
   int                stall_left = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   hsv_to_rgb_color DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fraction inputs above 1.0 count as exactly 1.0.
   function automatic longint unsigned clamp_fraction(logic [FB:0] x);
      return (x > ONE) ? longint'(ONE) : longint'(x);
   endfunction

   function automatic logic [CHAN_W-1:0] channel_byte(longint unsigned x);
      return CHAN_W'((x * 255) >> FB);
   endfunction

   // Expected packed RGBA word for one request.
   function automatic logic [RSP_W-1:0] rgba_of(hsv_request_type rq);
      longint unsigned s, v, a, h6, f, p, q, t, r, g, b;
      logic [SECTOR_W-1:0] sector;
      s = clamp_fraction(rq.saturation);
      v = clamp_fraction(rq.brightness);
      a = clamp_fraction(rq.opacity);
      h6 = longint'(rq.hue) * 6;
      sector = SECTOR_W'(h6 >> FB);
      f = h6 & (ONE - 1);
      p = (v * (ONE - s)) >> FB;
      q = (v * (ONE - ((s * f) >> FB))) >> FB;
      t = (v * (ONE - ((s * (ONE - f)) >> FB))) >> FB;
      if (s == 0) begin
         r = v; g = v; b = v;
      end else begin
         case (sector)
            SECTOR_RED_YELLOW: begin
               r = v; g = t; b = p;
            end
            SECTOR_YELLOW_GREEN: begin
               r = q; g = v; b = p;
            end
            SECTOR_GREEN_CYAN: begin
               r = p; g = v; b = t;
            end
            SECTOR_CYAN_BLUE: begin
               r = p; g = q; b = v;
            end
            SECTOR_BLUE_MAGENTA: begin
               r = t; g = p; b = v;
            end
            default: begin
               r = v; g = p; b = q;
            end
         endcase
      end
      return {channel_byte(a), channel_byte(b), channel_byte(g), channel_byte(r)};
   endfunction

   // Random fraction, weighted toward zero, exactly one and over-range values.
   function automatic logic [FB:0] random_fraction();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return (FB + 1)'(ONE);
         2:       return (FB + 1)'($urandom_range(ONE + 1, UNIT_MAX));
         default: return (FB + 1)'($urandom_range(0, ONE));
      endcase
   endfunction

   task automatic queue_request(int hue, int sat, int val, int alpha, int gap,
                                bit drain);
      hsv_request_type rq;
      rq.hue         = FB'(hue);
      rq.saturation  = (FB + 1)'(sat);
      rq.brightness  = (FB + 1)'(val);
      rq.opacity     = (FB + 1)'(alpha);
      rq.gap_before  = gap;
      rq.drain_first = drain;
      pending_requests = {pending_requests, rq};
   endtask

   task automatic report_mismatch(string what, logic [RSP_W-1:0] want,
                                  logic [RSP_W-1:0] got);
      $display("ERROR at %0t: %s, expected %08h, got %08h", $time, what, want, got);
      mismatch_count++;
   endtask

   // Request driver: holds each request until it is taken.
   always @(posedge clock) begin
      bit presenting;
      if (reset) begin
         req_tvalid <= 1'b0;
         request_loaded = 1'b0;
         gap_left = 0;
      end else begin
         presenting = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_colors = {expected_colors, rgba_of(current_request)};
            presenting = 1'b0;
         end
         if (!presenting) begin
            // A drain request waits until all earlier colors are back.
            if (!request_loaded && pending_requests.size() > 0 &&
                !(pending_requests[0].drain_first && expected_colors.size() > 0)) begin
               current_request = pending_requests.pop_front();
               gap_left = current_request.gap_before;
               request_loaded = 1'b1;
            end
            if (request_loaded && gap_left == 0) begin
               req_tdata <= req_word_type'({current_request.opacity,
                                            current_request.brightness,
                                            current_request.saturation,
                                            current_request.hue});
               request_loaded = 1'b0;
               presenting = 1'b1;
            end else if (request_loaded) begin
               gap_left--;
            end
         end
         req_tvalid <= presenting;
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colors.size() == 0) begin
               report_mismatch("response without a request", '0, rsp_tdata);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch("wrong color", want, rsp_tdata);
            end
         end
         // Stalls come in bursts, with quiet stretches and none near the end.
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (pending_requests.size() >= CALM_TAIL &&
                      (cycle_count / 300) % 3 != 2 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hsv_to_rgb_color: mismatch");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int gap;
      // Directed corners: extremes of every field, grey, and each sector edge.
      queue_request(0, 0, 0, 0, 0, 1'b0);
      queue_request(16'hFFFF, ONE, ONE, ONE, 0, 1'b0);
      queue_request(16'h1234, 0, ONE, ONE, 0, 1'b0);
      queue_request(16'hABCD, 0, 16'h8000, 16'h4000, 0, 1'b0);
      queue_request(16'h5555, UNIT_MAX, UNIT_MAX, UNIT_MAX, 0, 1'b0);
      queue_request(16'hFFFF, UNIT_MAX, ONE - 1, ONE - 1, 0, 1'b0);
      queue_request(0, ONE, ONE, 0, 0, 1'b0);
      queue_request(10923, ONE, ONE, ONE, 0, 1'b0);
      queue_request(10922, ONE, ONE, ONE, 0, 1'b0);
      queue_request(21846, ONE, ONE, ONE, 0, 1'b0);
      queue_request(21845, ONE, ONE, ONE, 0, 1'b0);
      queue_request(32768, ONE, ONE, ONE, 0, 1'b0);
      queue_request(32767, ONE, ONE, ONE, 0, 1'b0);
      queue_request(43691, ONE, ONE, ONE, 0, 1'b0);
      queue_request(43690, ONE, ONE, ONE, 0, 1'b0);
      queue_request(54614, ONE, ONE, ONE, 0, 1'b0);
      queue_request(54613, ONE, ONE, ONE, 0, 1'b0);
      queue_request(5000, 16'h8000, 16'hC000, ONE + 1, 0, 1'b0);
      queue_request(16000, 16'h3000, ONE + 7, 16'h1, 0, 1'b0);
      queue_request(27000, 1, ONE, ONE, 0, 1'b0);
      queue_request(38000, ONE - 1, 1, 16'h7FFF, 0, 1'b0);
      queue_request(49000, 16'hE000, 16'hFFFF, 16'hAAAA, 0, 1'b0);
      queue_request(60000, ONE, 16'h5555, UNIT_MAX, 0, 1'b0);

      // Random colors; some stretches run without gaps, the tail has none.
      for (int i = 0; i < RANDOM_REQS; i++) begin
         gap = 0;
         if (i < RANDOM_REQS - CALM_TAIL && (i / 100) % 3 != 2 &&
             $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
         queue_request($urandom_range(0, ONE - 1), random_fraction(),
                       random_fraction(), random_fraction(), gap,
                       i == 0 || i == RANDOM_REQS / 2);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || request_loaded || req_tvalid ||
             expected_colors.size() > 0)
         @(posedge clock);
      repeat (FLUSH_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("hsv_to_rgb_color: match");
      end else begin
         $display("hsv_to_rgb_color: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
